// File: src/dcrke_pkg.sv
// Package: constants, types and phase codes for the DER RSA key extractor.
`timescale 1ns / 1ps
package dcrke_pkg;
   localparam int MAX_MODULUS_BYTES = 512;
   localparam int CERT_LENGTH_BITS = 16;
   localparam int POS_W = CERT_LENGTH_BITS;

   typedef enum logic [3:0] {
      PH_OUTER = 4'd0, PH_TBS = 4'd1, PH_FIELD = 4'd2, PH_FIELD_SKIP = 4'd3,
      PH_SPKI = 4'd4, PH_ALG = 4'd5, PH_ALG_SKIP = 4'd6, PH_BITS = 4'd7,
      PH_UNUSED = 4'd8, PH_RSASEQ = 4'd9, PH_MOD = 4'd10, PH_MODVAL = 4'd11,
      PH_EXP = 4'd12, PH_EXPVAL = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      K_MOD = 2'd0, K_OK = 2'd1, K_ERR = 2'd2, K_NONE = 2'd3
   } kind_type;

   localparam logic [7:0] TAG_SEQ = 8'h30;
   localparam logic [7:0] TAG_BITS = 8'h03;
   localparam logic [7:0] TAG_INT = 8'h02;
   localparam logic [7:0] TAG_CTX0 = 8'hA0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic first_byte;
      logic [15:0] cert_length;
   } item_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] modulus_byte;
      logic [9:0] modulus_length;
      logic [31:0] exponent;
      logic last_result;
   } result_type;
endpackage

// File: src/dcrke_parser.sv
// Parser: per-byte DER header walk and result formation, one byte per cycle while item_valid is high.
`timescale 1ns / 1ps
module dcrke_parser (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  dcrke_pkg::item_type item,
   output logic res_valid,
   output dcrke_pkg::result_type res
);
   dcrke_pkg::phase_type phase_ff, phase_in;
   logic [dcrke_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [1:0] hstep_ff, hstep_in;
   logic [7:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [2:0] lbl_ff, lbl_in;
   logic [dcrke_pkg::POS_W-1:0] vbl_ff, vbl_in;
   logic [2:0] skip_ff, skip_in;
   logic [dcrke_pkg::POS_W-1:0] end0_ff, end0_in, end1_ff, end1_in, end2_ff, end2_in;
   logic [dcrke_pkg::POS_W-1:0] end3_ff, end3_in, end4_ff, end4_in;
   logic [31:0] exp_ff, exp_in;
   logic [10:0] mcnt_ff, mcnt_in;
   logic fin_ff, fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dcrke_pkg::PH_OUTER;
         fin_ff <= 1'b1;
         pos_ff <= '0; hstep_ff <= '0; tag_ff <= '0; len_ff <= '0; lbl_ff <= '0;
         vbl_ff <= '0; skip_ff <= '0; end0_ff <= '0; end1_ff <= '0; end2_ff <= '0;
         end3_ff <= '0; end4_ff <= '0; exp_ff <= '0; mcnt_ff <= '0;
      end else if (item_valid) begin
         phase_ff <= phase_in; fin_ff <= fin_in; pos_ff <= pos_in;
         hstep_ff <= hstep_in; tag_ff <= tag_in; len_ff <= len_in; lbl_ff <= lbl_in;
         vbl_ff <= vbl_in; skip_ff <= skip_in; end0_ff <= end0_in; end1_ff <= end1_in;
         end2_ff <= end2_in; end3_ff <= end3_in; end4_ff <= end4_in;
         exp_ff <= exp_in; mcnt_ff <= mcnt_in;
      end
   end

   always_comb begin
      dcrke_pkg::phase_type ph;
      logic [1:0] hs;
      logic [7:0] tg;
      logic [31:0] ln;
      logic [2:0] lb;
      logic [dcrke_pkg::POS_W-1:0] vb, e0, e1, e2, e3, e4, pos, lim;
      logic [2:0] sk;
      logic [31:0] ex;
      logic [10:0] mc;
      logic [7:0] b;
      dcrke_pkg::kind_type kind;
      logic hdone, strip, run;
      logic [32:0] vend;
      logic [31:0] eff;
      logic [dcrke_pkg::POS_W:0] pos1;

      b = item.data_byte;
      ph = phase_ff; hs = hstep_ff; tg = tag_ff; ln = len_ff; lb = lbl_ff; vb = vbl_ff;
      sk = skip_ff; e0 = end0_ff; e1 = end1_ff; e2 = end2_ff; e3 = end3_ff;
      e4 = end4_ff; ex = exp_ff; mc = mcnt_ff; pos = pos_ff; fin_in = fin_ff;
      run = 1'b1;
      if (item.first_byte) begin
         ph = dcrke_pkg::PH_OUTER; hs = '0; tg = '0; ln = '0; lb = '0; vb = '0;
         sk = '0; e1 = '0; e2 = '0; e3 = '0; e4 = '0; ex = '0; mc = '0; pos = '0;
         e0 = item.cert_length[dcrke_pkg::POS_W-1:0];
         fin_in = 1'b0;
      end else if (fin_ff) begin
         run = 1'b0;
      end
      kind = dcrke_pkg::K_NONE;
      hdone = 1'b0;
      strip = 1'b0;
      eff = '0;
      case (ph)
         dcrke_pkg::PH_OUTER, dcrke_pkg::PH_TBS: lim = e0;
         dcrke_pkg::PH_FIELD, dcrke_pkg::PH_SPKI: lim = e1;
         dcrke_pkg::PH_ALG, dcrke_pkg::PH_BITS: lim = e2;
         dcrke_pkg::PH_RSASEQ: lim = e3;
         default: lim = e4;
      endcase
      if (pos >= e0) begin
         kind = dcrke_pkg::K_ERR;
      end else begin
         case (ph)
            dcrke_pkg::PH_FIELD_SKIP, dcrke_pkg::PH_ALG_SKIP, dcrke_pkg::PH_UNUSED: begin
               if (vb != '0) vb = vb - 1'b1;
               if (vb == '0) begin
                  if (ph == dcrke_pkg::PH_FIELD_SKIP)
                     ph = (sk == '0) ? dcrke_pkg::PH_SPKI : dcrke_pkg::PH_FIELD;
                  else if (ph == dcrke_pkg::PH_ALG_SKIP) ph = dcrke_pkg::PH_BITS;
                  else ph = dcrke_pkg::PH_RSASEQ;
               end
            end
            dcrke_pkg::PH_MODVAL: begin
               kind = dcrke_pkg::K_MOD;
               if (hs != '0) begin
                  hs = '0;
                  eff = ln;
                  strip = (eff > 32'd1) && (b == 8'd0);
                  if (strip) eff = eff - 32'd1;
                  if (eff > 32'(dcrke_pkg::MAX_MODULUS_BYTES)) kind = dcrke_pkg::K_ERR;
                  else mc = eff[10:0];
               end
               if (kind != dcrke_pkg::K_ERR) begin
                  if (vb != '0) vb = vb - 1'b1;
                  if (vb == '0) ph = dcrke_pkg::PH_EXP;
                  if (strip) kind = dcrke_pkg::K_NONE;
               end
            end
            dcrke_pkg::PH_EXPVAL: begin
               if (hs != '0) begin
                  hs = '0;
                  eff = ln;
                  strip = (eff > 32'd1) && (b == 8'd0);
                  if (strip) eff = eff - 32'd1;
                  if (eff > 32'd4) kind = dcrke_pkg::K_ERR;
               end
               if (kind != dcrke_pkg::K_ERR) begin
                  if (!strip) ex = {ex[23:0], b};
                  if (vb != '0) vb = vb - 1'b1;
                  if (vb == '0) kind = dcrke_pkg::K_OK;
               end
            end
            default: begin
               if (pos >= lim) begin
                  kind = dcrke_pkg::K_ERR;
               end else if (hs == 2'd1) begin
                  if (!b[7]) begin
                     ln = {24'd0, b};
                     hdone = 1'b1;
                  end else if (b[6:0] == 7'd0 || b[6:0] > 7'd4) begin
                     kind = dcrke_pkg::K_ERR;
                  end else begin
                     lb = b[2:0]; ln = '0; hs = 2'd2;
                  end
               end else if (hs == 2'd2) begin
                  ln = {ln[23:0], b};
                  if (lb != '0) lb = lb - 1'b1;
                  if (lb == '0) hdone = 1'b1;
               end else begin
                  tg = b; hs = 2'd1;
               end
            end
         endcase
      end
      // header complete: bounds and tag checks, descend
      vend = {{(33-dcrke_pkg::POS_W){1'b0}}, pos} + 33'd1 + {1'b0, ln};
      if (hdone) begin
         if (vend > {{(33-dcrke_pkg::POS_W){1'b0}}, lim}) begin
            kind = dcrke_pkg::K_ERR;
         end else begin
            hs = '0;
            case (ph)
               dcrke_pkg::PH_OUTER: begin
                  if (tg != dcrke_pkg::TAG_SEQ) kind = dcrke_pkg::K_ERR;
                  else ph = dcrke_pkg::PH_TBS;
               end
               dcrke_pkg::PH_TBS: begin
                  if (tg != dcrke_pkg::TAG_SEQ) kind = dcrke_pkg::K_ERR;
                  else begin
                     e1 = vend[dcrke_pkg::POS_W-1:0]; sk = 3'd6; ph = dcrke_pkg::PH_FIELD;
                  end
               end
               dcrke_pkg::PH_FIELD: begin
                  if (sk == 3'd6) sk = (tg == dcrke_pkg::TAG_CTX0) ? 3'd5 : 3'd4;
                  else if (sk != '0) sk = sk - 1'b1;
                  if (ln == '0) ph = (sk == '0) ? dcrke_pkg::PH_SPKI : dcrke_pkg::PH_FIELD;
                  else begin
                     vb = ln[dcrke_pkg::POS_W-1:0]; ph = dcrke_pkg::PH_FIELD_SKIP;
                  end
               end
               dcrke_pkg::PH_SPKI: begin
                  if (tg != dcrke_pkg::TAG_SEQ) kind = dcrke_pkg::K_ERR;
                  else begin
                     e2 = vend[dcrke_pkg::POS_W-1:0]; ph = dcrke_pkg::PH_ALG;
                  end
               end
               dcrke_pkg::PH_ALG: begin
                  if (ln == '0) ph = dcrke_pkg::PH_BITS;
                  else begin
                     vb = ln[dcrke_pkg::POS_W-1:0]; ph = dcrke_pkg::PH_ALG_SKIP;
                  end
               end
               dcrke_pkg::PH_BITS: begin
                  if (tg != dcrke_pkg::TAG_BITS || ln == '0) kind = dcrke_pkg::K_ERR;
                  else begin
                     e3 = vend[dcrke_pkg::POS_W-1:0];
                     vb = {{(dcrke_pkg::POS_W-1){1'b0}}, 1'b1};
                     ph = dcrke_pkg::PH_UNUSED;
                  end
               end
               dcrke_pkg::PH_RSASEQ: begin
                  if (tg != dcrke_pkg::TAG_SEQ) kind = dcrke_pkg::K_ERR;
                  else begin
                     e4 = vend[dcrke_pkg::POS_W-1:0]; ph = dcrke_pkg::PH_MOD;
                  end
               end
               dcrke_pkg::PH_MOD: begin
                  if (tg != dcrke_pkg::TAG_INT) kind = dcrke_pkg::K_ERR;
                  else if (ln == '0) begin
                     mc = '0; ph = dcrke_pkg::PH_EXP;
                  end else begin
                     vb = ln[dcrke_pkg::POS_W-1:0]; hs = 2'd1; ph = dcrke_pkg::PH_MODVAL;
                  end
               end
               default: begin
                  if (tg != dcrke_pkg::TAG_INT || ln == '0 || ln > 32'd5)
                     kind = dcrke_pkg::K_ERR;
                  else begin
                     vb = ln[dcrke_pkg::POS_W-1:0]; ex = '0; hs = 2'd1;
                     ph = dcrke_pkg::PH_EXPVAL;
                  end
               end
            endcase
         end
      end
      pos1 = {1'b0, pos} + 1'b1;
      if (kind != dcrke_pkg::K_OK && kind != dcrke_pkg::K_ERR
          && pos1 >= {1'b0, e0}) kind = dcrke_pkg::K_ERR;

      phase_in = ph; hstep_in = hs; tag_in = tg; len_in = ln; lbl_in = lb; vbl_in = vb;
      skip_in = sk; end0_in = e0; end1_in = e1; end2_in = e2; end3_in = e3;
      end4_in = e4; exp_in = ex; mcnt_in = mc; pos_in = pos1[dcrke_pkg::POS_W-1:0];
      if (run && (kind == dcrke_pkg::K_OK || kind == dcrke_pkg::K_ERR)) fin_in = 1'b1;
      if (!run) begin
         phase_in = phase_ff; hstep_in = hstep_ff; tag_in = tag_ff; len_in = len_ff;
         lbl_in = lbl_ff; vbl_in = vbl_ff; skip_in = skip_ff; end0_in = end0_ff;
         end1_in = end1_ff; end2_in = end2_ff; end3_in = end3_ff; end4_in = end4_ff;
         exp_in = exp_ff; mcnt_in = mcnt_ff; pos_in = pos_ff;
      end

      res_valid = run && (kind != dcrke_pkg::K_NONE);
      res.kind = kind;
      res.modulus_byte = (kind == dcrke_pkg::K_MOD) ? b : 8'd0;
      res.modulus_length = (kind == dcrke_pkg::K_MOD || kind == dcrke_pkg::K_OK)
                           ? mc[9:0] : 10'd0;
      res.exponent = (kind == dcrke_pkg::K_OK) ? ex : 32'd0;
      res.last_result = (kind == dcrke_pkg::K_OK || kind == dcrke_pkg::K_ERR);
   end
endmodule

// File: src/dcrke_out_buf.sv
// Output skid buffer: two-entry result queue with registered ready.
`timescale 1ns / 1ps
module dcrke_out_buf (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  dcrke_pkg::result_type in_data,
   output logic in_ready,
   output logic out_valid,
   output dcrke_pkg::result_type out_data,
   input  logic out_ready
);
   dcrke_pkg::result_type main_ff, skid_ff;
   logic main_v_ff, skid_v_ff;

   assign in_ready = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!main_v_ff || out_ready) begin
            if (skid_v_ff) begin
               main_ff <= skid_ff;
               main_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               main_v_ff <= in_valid && in_ready;
               if (in_valid) main_ff <= in_data;
            end
         end else if (in_valid && in_ready) begin
            skid_ff <= in_data;
            skid_v_ff <= 1'b1;
         end
      end
   end
endmodule

// File: src/der_certificate_rsa_key_extractor.sv
// Top level: DER certificate stream in, RSA modulus bytes and exponent out.
`timescale 1ns / 1ps
// Takes one certificate byte per req beat (first_byte restarts the parse and
// samples cert_length) and walks the X.509 structure down to the RSA public
// key. Each modulus byte comes out as a kind-0 rsp beat, most significant
// first, with any sign pad byte stripped; the walk ends with one kind-1 beat
// carrying the exponent or one kind-2 error beat, both with tlast set. After
// that, bytes without first_byte are swallowed. Throughput is one byte per
// clock while req_tready is high: the header walk is a single registered
// stage, and a result is registered in the output buffer before it shows up
// on rsp. A two-entry output buffer keeps req_tready high while one result
// waits on rsp_tready; it drops only while both entries are full.
module der_certificate_rsa_key_extractor (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,  // [7:0] data_byte, [23:8] cert_length
   input  logic req_tuser,         // first_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,  // [7:0] modulus_byte, [17:8] modulus_length,
                                   // [49:18] exponent, [55:50] zero
   output logic [1:0] rsp_tuser,   // result_kind
   output logic rsp_tlast          // last_result
);
   dcrke_pkg::item_type item;
   dcrke_pkg::result_type res, out_res;
   logic res_valid, buf_ready;

   assign req_tready = buf_ready;
   assign item.data_byte = req_tdata[7:0];
   assign item.cert_length = req_tdata[23:8];
   assign item.first_byte = req_tuser;

   dcrke_parser u_parser (
      .clock(clock), .reset(reset),
      .item_valid(req_tvalid && buf_ready), .item(item),
      .res_valid(res_valid), .res(res)
   );

   // a result only exists for a beat actually on the bus
   dcrke_out_buf u_out_buf (
      .clock(clock), .reset(reset),
      .in_valid(res_valid && req_tvalid), .in_data(res), .in_ready(buf_ready),
      .out_valid(rsp_tvalid), .out_data(out_res), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {6'd0, out_res.exponent, out_res.modulus_length, out_res.modulus_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last_result;
endmodule
